// File: rtl/core/pid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_pkg
// Shared widths, reset values and register indexes for the PID regulator.
// ----------------------------------------------------------------------------
package pid_pkg;

  // Field and state widths
  localparam int POS_W   = 13;            // sensor position / setpoint
  localparam int DT_W    = 16;            // elapsed time, 2^-20 s units
  localparam int GAIN_W  = 32;            // Q8.24 gains
  localparam int ACC_W   = 48;            // integral accumulator
  localparam int ERR_W   = POS_W + 2;     // signed error
  localparam int EMAG_W  = ERR_W - 1;     // |error|
  localparam int DIFF_W  = ERR_W + 1;     // signed error difference
  localparam int DMAG_W  = DIFF_W - 1;    // |error difference|
  localparam int FRAC_SH = 20;            // derivative scale 2^20
  localparam int QUO_W   = DMAG_W + FRAC_SH;
  localparam int OUT_W   = 32;            // Q16.16 result
  localparam int OUT_SH  = 28;            // 2^-44 down to 2^-16

  // Serial product widths
  localparam int PINT_W  = EMAG_W + DT_W;
  localparam int PE_W    = EMAG_W + GAIN_W;
  localparam int PD_W    = QUO_W + GAIN_W;
  localparam int PI_W    = ACC_W + GAIN_W;

  // Summation width: largest shifted term plus sign and carry headroom
  localparam int SUM_W   = ((PD_W + FRAC_SH) > PI_W ? (PD_W + FRAC_SH) : PI_W) + 3;
  localparam int PE_PAD  = SUM_W - PE_W - FRAC_SH;
  localparam int PD_PAD  = SUM_W - PD_W - FRAC_SH;
  localparam int PI_PAD  = SUM_W - PI_W;

  // Step counter covers the longest serial pass
  localparam int MUL_N   = (QUO_W > ACC_W) ? QUO_W : ACC_W;
  localparam int CNT_W   = $clog2(MUL_N + 1);

  // Stream packing
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 32;

  // Configuration registers
  localparam int CFG_IDX_W = 2;
  localparam int CFG_W     = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET = 2'd0,
    CFG_KP     = 2'd1,
    CFG_KI     = 2'd2,
    CFG_KD     = 2'd3
  } cfg_idx_e;

  localparam logic [POS_W-1:0]  TARGET_RST = POS_W'(3500);
  localparam logic [GAIN_W-1:0] KP_RST     = GAIN_W'(654311);
  localparam logic [GAIN_W-1:0] KI_RST     = GAIN_W'(3738922);
  localparam logic [GAIN_W-1:0] KD_RST     = GAIN_W'(28626);

endpackage

// File: rtl/core/pid_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_div
// Bit-serial restoring divider for the derivative term: (|diff| << 20) / dt,
// one quotient bit per cycle.
// ----------------------------------------------------------------------------
module pid_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pid_pkg::DMAG_W-1:0]  dmag_i,
  input  logic [pid_pkg::DT_W-1:0]    divisor_i,
  output logic                        done_o,
  output logic [pid_pkg::QUO_W-1:0]   quot_o
);

  logic                        busy_q, busy_d;
  logic                        done_q, done_d;
  logic [pid_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [pid_pkg::DT_W-1:0]    rem_q, rem_d;
  logic [pid_pkg::DT_W-1:0]    div_q, div_d;
  logic [pid_pkg::QUO_W-1:0]   quo_q, quo_d;
  logic [pid_pkg::DT_W:0]      trial;

  // One restoring step: shift in next dividend bit, try subtract
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    div_d  = div_q;
    quo_d  = quo_q;
    trial  = {rem_q, quo_q[pid_pkg::QUO_W-1]} - {1'b0, div_q};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      div_d  = divisor_i;
      quo_d  = {dmag_i, {pid_pkg::FRAC_SH{1'b0}}};
    end else if (busy_q) begin
      if (!trial[pid_pkg::DT_W]) begin
        rem_d = trial[pid_pkg::DT_W-1:0];
      end else begin
        rem_d = {rem_q[pid_pkg::DT_W-2:0], quo_q[pid_pkg::QUO_W-1]};
      end
      quo_d = {quo_q[pid_pkg::QUO_W-2:0], ~trial[pid_pkg::DT_W]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == pid_pkg::CNT_W'(pid_pkg::QUO_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath, no reset needed
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    div_q <= div_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

// File: rtl/core/pid_controller_variable_dt_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_variable_dt_core
// Parallel-form PID regulator with variable step time, bit-serial datapath.
// ----------------------------------------------------------------------------
// A control step (tuser 0) runs from input beat to result beat through the
// bit-serial divider that forms the derivative (one quotient bit per cycle,
// error * dt formed alongside), the saturating integral update and operand
// load, three bit-serial gain multipliers running side by side (paced by the
// 48-bit integral), signed summation and clipping.
// One step is worked on at a time; input is taken again once the result
// sits in the output register, even if that beat has not yet been taken.
// A clear request (tuser 1) zeroes previous error and integral in its
// accept cycle and gives no result beat. Output is Q16.16 with a flag that
// marks clipping of the output or the integral in that step.
// ----------------------------------------------------------------------------
module pid_controller_variable_dt_core (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [pid_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [12:0] position, [28:13] delta_time
  input  logic                             s_axis_tuser,  // [0] func
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [pid_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // [31:0] control_value
  output logic                             m_axis_tuser,  // [0] output_saturated
  // configuration write port
  input  logic                             cfg_we_i,
  input  logic [pid_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [pid_pkg::CFG_W-1:0]        cfg_wdata_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_DIV, ST_INTEG, ST_LOAD, ST_MUL,
    ST_SUM_E, ST_SUM_D, ST_SUM_I, ST_OUT
  } state_e;

  // Configuration
  logic [pid_pkg::POS_W-1:0]   target_q;
  logic [pid_pkg::GAIN_W-1:0]  kp_q, ki_q, kd_q;

  // Control and state
  state_e                      state_q, state_d;
  logic [pid_pkg::CNT_W-1:0]   cnt_q, cnt_d;
  logic [pid_pkg::ERR_W-1:0]   prev_err_q, prev_err_d;
  logic [pid_pkg::ACC_W-1:0]   integ_q, integ_d;
  logic                        sat_q, sat_d;
  logic                        out_valid_q, out_valid_d;
  logic [pid_pkg::OUT_W-1:0]   out_data_q, out_data_d;
  logic                        out_sat_q, out_sat_d;

  // Datapath
  logic [pid_pkg::ERR_W-1:0]   err_q, err_d;
  logic                        dneg_q, dneg_d;
  logic [pid_pkg::DT_W-1:0]    dt_q, dt_d;
  logic [pid_pkg::PINT_W-1:0]  pint_q, pint_d;
  logic [pid_pkg::PE_W-1:0]    pe_q, pe_d;
  logic [pid_pkg::PD_W-1:0]    pd_q, pd_d;
  logic [pid_pkg::PI_W-1:0]    pi_q, pi_d;
  logic [pid_pkg::SUM_W-1:0]   acc_q, acc_d;

  // Combinational helpers
  logic                        in_fire;
  logic                        step_req;
  logic [pid_pkg::POS_W-1:0]   in_pos;
  logic [pid_pkg::DT_W-1:0]    in_dt;
  logic [pid_pkg::ERR_W-1:0]   err_new;
  logic [pid_pkg::ERR_W-1:0]   err_abs_new;
  logic [pid_pkg::DIFF_W-1:0]  diff;
  logic [pid_pkg::DIFF_W-1:0]  diff_abs;
  logic [pid_pkg::DT_W-1:0]    divisor;
  logic                        div_done;
  logic [pid_pkg::QUO_W-1:0]   quot;
  logic [pid_pkg::ERR_W-1:0]   err_abs;
  logic [pid_pkg::ACC_W:0]     prod_ext;
  logic [pid_pkg::ACC_W:0]     integ_sum;
  logic [pid_pkg::ACC_W-1:0]   integ_abs;
  logic [pid_pkg::DT_W:0]      pint_add;
  logic [pid_pkg::GAIN_W:0]    pe_add, pd_add, pi_add;
  logic [pid_pkg::SUM_W-1:0]   sum_op;
  logic                        sum_neg;
  logic [pid_pkg::SUM_W-1:0]   sum_base;
  logic [pid_pkg::SUM_W-pid_pkg::OUT_W-pid_pkg::OUT_SH:0] acc_top;
  logic                        acc_fits;

  assign in_pos   = s_axis_tdata[pid_pkg::POS_W-1:0];
  assign in_dt    = s_axis_tdata[pid_pkg::POS_W +: pid_pkg::DT_W];
  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire  = s_axis_tvalid && s_axis_tready;
  assign step_req = in_fire && !s_axis_tuser;

  // Error, difference and divisor at accept
  assign err_new     = pid_pkg::ERR_W'({2'b00, in_pos}) - pid_pkg::ERR_W'({2'b00, target_q});
  assign err_abs_new = err_new[pid_pkg::ERR_W-1] ? (~err_new + 1'b1) : err_new;
  assign diff        = {err_new[pid_pkg::ERR_W-1], err_new}
                     - {prev_err_q[pid_pkg::ERR_W-1], prev_err_q};
  assign diff_abs    = diff[pid_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign divisor     = (in_dt == '0) ? pid_pkg::DT_W'(1) : in_dt;

  pid_div u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (step_req),
    .dmag_i    (diff_abs[pid_pkg::DMAG_W-1:0]),
    .divisor_i (divisor),
    .done_o    (div_done),
    .quot_o    (quot)
  );

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= pid_pkg::TARGET_RST;
      kp_q     <= pid_pkg::KP_RST;
      ki_q     <= pid_pkg::KI_RST;
      kd_q     <= pid_pkg::KD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        pid_pkg::CFG_TARGET: target_q <= cfg_wdata_i[pid_pkg::POS_W-1:0];
        pid_pkg::CFG_KP:     kp_q     <= cfg_wdata_i[pid_pkg::GAIN_W-1:0];
        pid_pkg::CFG_KI:     ki_q     <= cfg_wdata_i[pid_pkg::GAIN_W-1:0];
        pid_pkg::CFG_KD:     kd_q     <= cfg_wdata_i[pid_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Serial multiplier steps: add multiplicand (gain, or dt) into upper half on LSB, shift right
  assign err_abs  = err_q[pid_pkg::ERR_W-1] ? (~err_q + 1'b1) : err_q;
  assign pint_add = {1'b0, pint_q[pid_pkg::PINT_W-1:pid_pkg::EMAG_W]}
                  + (pint_q[0] ? {1'b0, dt_q} : '0);
  assign pe_add   = {1'b0, pe_q[pid_pkg::PE_W-1:pid_pkg::EMAG_W]}
                  + (pe_q[0] ? {1'b0, kp_q} : '0);
  assign pd_add   = {1'b0, pd_q[pid_pkg::PD_W-1:pid_pkg::QUO_W]}
                  + (pd_q[0] ? {1'b0, kd_q} : '0);
  assign pi_add   = {1'b0, pi_q[pid_pkg::PI_W-1:pid_pkg::ACC_W]}
                  + (pi_q[0] ? {1'b0, ki_q} : '0);

  // Saturating integral update
  always_comb begin
    prod_ext = {{(pid_pkg::ACC_W + 1 - pid_pkg::PINT_W){1'b0}}, pint_q};
    if (err_q[pid_pkg::ERR_W-1]) begin
      prod_ext = ~prod_ext + 1'b1;
    end
    integ_sum = {integ_q[pid_pkg::ACC_W-1], integ_q} + prod_ext;
  end

  assign integ_abs = integ_q[pid_pkg::ACC_W-1] ? (~integ_q + 1'b1) : integ_q;

  // Summation operand select
  always_comb begin
    sum_op   = '0;
    sum_neg  = 1'b0;
    sum_base = acc_q;
    case (state_q)
      ST_SUM_E: begin
        sum_op   = {{pid_pkg::PE_PAD{1'b0}}, pe_q, {pid_pkg::FRAC_SH{1'b0}}};
        sum_neg  = err_q[pid_pkg::ERR_W-1];
        sum_base = '0;
      end
      ST_SUM_D: begin
        sum_op  = {{pid_pkg::PD_PAD{1'b0}}, pd_q, {pid_pkg::FRAC_SH{1'b0}}};
        sum_neg = dneg_q;
      end
      ST_SUM_I: begin
        sum_op  = {{pid_pkg::PI_PAD{1'b0}}, pi_q};
        sum_neg = integ_q[pid_pkg::ACC_W-1];
      end
      default: ;
    endcase
  end

  // Output clip: result fits when all bits above it match its sign
  assign acc_top  = acc_q[pid_pkg::SUM_W-1:pid_pkg::OUT_SH+pid_pkg::OUT_W-1];
  assign acc_fits = (&acc_top) || !(|acc_top);

  // Sequencer
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    prev_err_d  = prev_err_q;
    integ_d     = integ_q;
    sat_d       = sat_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_sat_d   = out_sat_q;
    err_d       = err_q;
    dneg_d      = dneg_q;
    dt_d        = dt_q;
    pint_d      = pint_q;
    pe_d        = pe_q;
    pd_d        = pd_q;
    pi_d        = pi_q;
    acc_d       = acc_q;

    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          if (s_axis_tuser) begin
            prev_err_d = '0;
            integ_d    = '0;
          end else begin
            err_d      = err_new;
            prev_err_d = err_new;
            dneg_d     = diff[pid_pkg::DIFF_W-1];
            dt_d       = in_dt;
            pint_d     = {{pid_pkg::DT_W{1'b0}}, err_abs_new[pid_pkg::EMAG_W-1:0]};
            cnt_d      = '0;
            state_d    = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        // error * dt runs alongside the divide
        if (cnt_q < pid_pkg::CNT_W'(pid_pkg::EMAG_W)) begin
          pint_d = {pint_add, pint_q[pid_pkg::EMAG_W-1:1]};
          cnt_d  = cnt_q + 1'b1;
        end
        if (div_done) begin
          state_d = ST_INTEG;
        end
      end
      ST_INTEG: begin
        if (integ_sum[pid_pkg::ACC_W] != integ_sum[pid_pkg::ACC_W-1]) begin
          integ_d = integ_sum[pid_pkg::ACC_W]
                  ? {1'b1, {(pid_pkg::ACC_W-1){1'b0}}}
                  : {1'b0, {(pid_pkg::ACC_W-1){1'b1}}};
          sat_d   = 1'b1;
        end else begin
          integ_d = integ_sum[pid_pkg::ACC_W-1:0];
          sat_d   = 1'b0;
        end
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        pe_d    = {{pid_pkg::GAIN_W{1'b0}}, err_abs[pid_pkg::EMAG_W-1:0]};
        pd_d    = {{pid_pkg::GAIN_W{1'b0}}, quot};
        pi_d    = {{pid_pkg::GAIN_W{1'b0}}, integ_abs};
        cnt_d   = '0;
        state_d = ST_MUL;
      end
      ST_MUL: begin
        if (cnt_q < pid_pkg::CNT_W'(pid_pkg::EMAG_W)) begin
          pe_d = {pe_add, pe_q[pid_pkg::EMAG_W-1:1]};
        end
        if (cnt_q < pid_pkg::CNT_W'(pid_pkg::QUO_W)) begin
          pd_d = {pd_add, pd_q[pid_pkg::QUO_W-1:1]};
        end
        if (cnt_q < pid_pkg::CNT_W'(pid_pkg::ACC_W)) begin
          pi_d = {pi_add, pi_q[pid_pkg::ACC_W-1:1]};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == pid_pkg::CNT_W'(pid_pkg::MUL_N - 1)) begin
          state_d = ST_SUM_E;
        end
      end
      ST_SUM_E, ST_SUM_D, ST_SUM_I: begin
        acc_d = sum_base + (sum_neg ? ~sum_op : sum_op)
              + {{(pid_pkg::SUM_W-1){1'b0}}, sum_neg};
        case (state_q)
          ST_SUM_E: state_d = ST_SUM_D;
          ST_SUM_D: state_d = ST_SUM_I;
          default:  state_d = ST_OUT;
        endcase
      end
      ST_OUT: begin
        // hand off once the output register is free or being drained
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          if (acc_fits) begin
            out_data_d = acc_q[pid_pkg::OUT_SH +: pid_pkg::OUT_W];
            out_sat_d  = sat_q;
          end else begin
            out_data_d = acc_q[pid_pkg::SUM_W-1]
                       ? {1'b1, {(pid_pkg::OUT_W-1){1'b0}}}
                       : {1'b0, {(pid_pkg::OUT_W-1){1'b1}}};
            out_sat_d  = 1'b1;
          end
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      prev_err_q  <= '0;
      integ_q     <= '0;
      sat_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      prev_err_q  <= prev_err_d;
      integ_q     <= integ_d;
      sat_q       <= sat_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_sat_q  <= out_sat_d;
    err_q      <= err_d;
    dneg_q     <= dneg_d;
    dt_q       <= dt_d;
    pint_q     <= pint_d;
    pe_q       <= pe_d;
    pd_q       <= pd_d;
    pi_q       <= pi_d;
    acc_q      <= acc_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_sat_q;

endmodule
